@@ sv/repf_pkg.sv @@
package repf_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_EDGE   = 2'd1,
    REQ_BUTTON = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam logic [CfgIdxWidth-1:0] RegEnable      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegQuietTimeout = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegPitchStart  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegPitchStep   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegPitchMin    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegPitchMax    = 3'd5;

  // Register reset values
  localparam logic [15:0] TimeoutReset    = 16'd1000;
  localparam logic [14:0] PitchStartReset = 15'd2000;
  localparam logic [9:0]  PitchStepReset  = 10'd100;
  localparam logic [14:0] PitchMinReset   = 15'd100;
  localparam logic [14:0] PitchMaxReset   = 15'd20000;

  // Tone constants
  localparam logic [14:0] PressHz   = 15'd500;
  localparam logic [14:0] ReleaseHz = 15'd700;
  localparam logic [4:0]  RotateMs  = 5'd5;
  localparam logic [4:0]  ButtonMs  = 5'd20;

  typedef struct packed {
    logic        enable;
    logic [15:0] quiet_timeout_ms;
    logic [14:0] pitch_start;
    logic [9:0]  pitch_step;
    logic [14:0] pitch_min;
    logic [14:0] pitch_max;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] diff;
    logic               pressed;
    logic               tone_valid;
    logic [14:0]        tone_hz;
    logic [4:0]         tone_ms;
  } result_t;

endpackage

@@ sv/repf_cfg_regs.sv @@
module repf_cfg_regs
  import repf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write,
  input  logic [CfgIdxWidth-1:0]  index,
  input  logic [CfgDataWidth-1:0] data,
  output cfg_t                    cfg
);

  // Register file; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= 1'b1;
      cfg.quiet_timeout_ms <= TimeoutReset;
      cfg.pitch_start      <= PitchStartReset;
      cfg.pitch_step       <= PitchStepReset;
      cfg.pitch_min        <= PitchMinReset;
      cfg.pitch_max        <= PitchMaxReset;
    end else if (write) begin
      unique case (index)
        RegEnable:       cfg.enable           <= data[0];
        RegQuietTimeout: cfg.quiet_timeout_ms <= data;
        RegPitchStart:   cfg.pitch_start      <= data[14:0];
        RegPitchStep:    cfg.pitch_step       <= data[9:0];
        RegPitchMin:     cfg.pitch_min        <= data[14:0];
        RegPitchMax:     cfg.pitch_max        <= data[14:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/repf_core.sv @@
module repf_core
  import repf_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_kind_t req_type,
  input  logic      line_a,
  input  logic      line_b,
  input  logic      button_low,
  input  cfg_t      cfg,
  output result_t   result
);

  localparam logic signed [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [32:0] DiffMax = 33'sd32767;
  localparam logic signed [32:0] DiffMin = -33'sd32768;

  logic signed [COUNT_WIDTH-1:0] detent_count, detent_count_next;
  logic                          counting_blocked, counting_blocked_next;
  logic                          button_level, button_level_next;
  logic                          reported_pressed, reported_pressed_next;
  logic [14:0]                   pitch_now, pitch_now_next;
  logic [15:0]                   quiet_elapsed, quiet_elapsed_next;

  logic                          up;
  logic signed [COUNT_WIDTH-1:0] count_stepped;
  logic signed [16:0]            pitch_moved;
  logic [14:0]                   pitch_clamped;
  logic signed [32:0]            count_wide;
  logic signed [15:0]            diff_clamped;
  logic                          pressed;

  // Saturating detent count
  assign up = line_a ^ line_b;
  always_comb begin
    if (up) begin
      count_stepped = (detent_count == CountMax) ? detent_count : detent_count + 1'b1;
    end else begin
      count_stepped = (detent_count == CountMin) ? detent_count : detent_count - 1'b1;
    end
  end

  // Pitch step and clamp, min checked first
  assign pitch_moved = up ? $signed({2'b00, pitch_now}) + $signed({7'd0, cfg.pitch_step})
                          : $signed({2'b00, pitch_now}) - $signed({7'd0, cfg.pitch_step});
  always_comb begin
    if (pitch_moved < $signed({2'b00, cfg.pitch_min})) begin
      pitch_clamped = cfg.pitch_min;
    end else if (pitch_moved > $signed({2'b00, cfg.pitch_max})) begin
      pitch_clamped = cfg.pitch_max;
    end else begin
      pitch_clamped = pitch_moved[14:0];
    end
  end

  // Read value clamped to 16-bit signed
  assign count_wide = {{(33-COUNT_WIDTH){detent_count[COUNT_WIDTH-1]}}, detent_count};
  always_comb begin
    if (count_wide > DiffMax) begin
      diff_clamped = 16'sh7FFF;
    end else if (count_wide < DiffMin) begin
      diff_clamped = 16'sh8000;
    end else begin
      diff_clamped = count_wide[15:0];
    end
  end

  assign pressed = cfg.enable & button_level;

  // Request decode and state update
  always_comb begin
    detent_count_next     = detent_count;
    counting_blocked_next = counting_blocked;
    button_level_next     = button_level;
    reported_pressed_next = reported_pressed;
    pitch_now_next        = pitch_now;
    quiet_elapsed_next    = quiet_elapsed;
    result                = '0;
    if (fire) begin
      unique case (req_type)
        REQ_TICK: begin
          if (quiet_elapsed != 16'hFFFF) quiet_elapsed_next = quiet_elapsed + 16'd1;
        end
        REQ_EDGE: begin
          if (cfg.enable && !counting_blocked) begin
            detent_count_next  = count_stepped;
            pitch_now_next     = (quiet_elapsed > cfg.quiet_timeout_ms) ? cfg.pitch_start
                                                                        : pitch_clamped;
            quiet_elapsed_next = '0;
            result.tone_valid  = 1'b1;
            result.tone_hz     = pitch_now_next;
            result.tone_ms     = RotateMs;
          end
        end
        REQ_BUTTON: begin
          button_level_next     = button_low;
          counting_blocked_next = cfg.enable & button_low;
        end
        REQ_READ: begin
          detent_count_next = '0;
          result.diff       = diff_clamped;
          result.pressed    = pressed;
          if (pressed != reported_pressed) begin
            result.tone_valid     = 1'b1;
            result.tone_hz        = pressed ? PressHz : ReleaseHz;
            result.tone_ms        = ButtonMs;
            reported_pressed_next = pressed;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_count     <= '0;
      counting_blocked <= 1'b0;
      button_level     <= 1'b0;
      reported_pressed <= 1'b0;
      pitch_now        <= PitchStartReset;
      quiet_elapsed    <= '0;
    end else begin
      detent_count     <= detent_count_next;
      counting_blocked <= counting_blocked_next;
      button_level     <= button_level_next;
      reported_pressed <= reported_pressed_next;
      pitch_now        <= pitch_now_next;
      quiet_elapsed    <= quiet_elapsed_next;
    end
  end

endmodule

@@ sv/rotary_encoder_pitch_feedback_core.sv @@
// Channel | Signals                                          | Direction
// --------+--------------------------------------------------+----------
// in      | in_valid/in_ready, req_type line_a line_b        | in
//         | button_low                                       |
// out     | out_valid/out_ready, diff_out pressed_out        | out
//         | tone_valid tone_hz tone_ms                       |
// cfg     | cfg_valid/cfg_ready, cfg_index cfg_data          | in
//
// One request per clock sustained while out_ready holds high; a request moves
// through the input register, then the result register.
// Synchronous active-high reset clears control and counters, presets cfg.
// A stalled output holds the result register; the input register still takes
// one more request, then in_ready drops until the result moves.
// cfg_ready is always high; writes land the next cycle.
module rotary_encoder_pitch_feedback_core
  import repf_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic                    line_a,
  input  logic                    line_b,
  input  logic                    button_low,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      diff_out,
  output logic                    pressed_out,
  output logic                    tone_valid,
  output logic [14:0]             tone_hz,
  output logic [4:0]              tone_ms,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t      cfg;
  result_t   result;
  result_t   out_q;
  logic      in_q_valid;
  req_kind_t in_q_type;
  logic      in_q_a;
  logic      in_q_b;
  logic      in_q_button;
  logic      advance;

  assign cfg_ready = 1'b1;

  repf_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .write (cfg_valid & cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Handshake: move the held request into the result register when it is free
  assign advance  = in_q_valid & (~out_valid | out_ready);
  assign in_ready = ~in_q_valid | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_type   <= req_kind_t'(req_type);
      in_q_a      <= line_a;
      in_q_b      <= line_b;
      in_q_button <= button_low;
    end
  end

  repf_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .req_type   (in_q_type),
    .line_a     (in_q_a),
    .line_b     (in_q_b),
    .button_low (in_q_button),
    .cfg        (cfg),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign diff_out    = out_q.diff;
  assign pressed_out = out_q.pressed;
  assign tone_valid  = out_q.tone_valid;
  assign tone_hz     = out_q.tone_hz;
  assign tone_ms     = out_q.tone_ms;

`ifndef ASSERT_OFF
  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_held_request_kept: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid)
    else $error("held request lost while output stalled");

  a_tone_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_valid |-> (tone_ms == RotateMs || tone_ms == ButtonMs))
    else $error("tone with bad length");

  a_no_tone_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tone_valid |-> (tone_hz == '0 && tone_ms == '0))
    else $error("tone fields set without tone");
`endif

endmodule

@@ verif/pitch_feedback_checker.sv @@
module pitch_feedback_checker
  import repf_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic                    line_a,
  input  logic                    line_b,
  input  logic                    button_low,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [15:0]      diff_out,
  input  logic                    pressed_out,
  input  logic                    tone_valid,
  input  logic [14:0]             tone_hz,
  input  logic [4:0]              tone_ms,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output int                      mismatch_count,
  output int                      outstanding,
  output int                      results_checked,
  output int                      tones_heard
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CountTop    = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
  localparam longint CountBottom = -CountTop - 1;
  localparam int     ReportLimit = 40;

  // Shadow copy of the registers and the block state
  cfg_t        regs;
  longint      detent_count;
  logic        counting_blocked;
  logic        button_level;
  logic        reported_pressed;
  logic [14:0] pitch_now;
  logic [15:0] quiet_elapsed;

  // Results still owed by the block, oldest first
  result_t pending_feedback[$];

  // Advance the shadow state by one request and return the result it causes
  function automatic result_t feedback_for_request(req_kind_t kind, logic a, logic b,
                                                   logic btn);
    result_t     r;
    int          p;
    longint      d;
    logic        pressed_now;
    r = '0;
    case (kind)
      REQ_TICK: begin
        if (quiet_elapsed != 16'hFFFF) quiet_elapsed = quiet_elapsed + 16'd1;
      end
      REQ_EDGE: begin
        if (regs.enable && !counting_blocked) begin
          // A differing from B turns up, otherwise down
          if (a != b) begin
            if (detent_count < CountTop) detent_count++;
          end else if (detent_count > CountBottom) begin
            detent_count--;
          end
          if (quiet_elapsed > regs.quiet_timeout_ms) begin
            pitch_now = regs.pitch_start;
          end else begin
            p = (a != b) ? int'(pitch_now) + int'(regs.pitch_step)
                         : int'(pitch_now) - int'(regs.pitch_step);
            // min wins over max when the bounds are inverted
            if (p < int'(regs.pitch_min)) p = int'(regs.pitch_min);
            else if (p > int'(regs.pitch_max)) p = int'(regs.pitch_max);
            pitch_now = p[14:0];
          end
          quiet_elapsed = '0;
          r.tone_valid  = 1'b1;
          r.tone_hz     = pitch_now;
          r.tone_ms     = RotateMs;
        end
      end
      REQ_BUTTON: begin
        button_level     = btn;
        counting_blocked = regs.enable & btn;
      end
      default: begin
        d = detent_count;
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        detent_count = 0;
        r.diff       = d[15:0];
        pressed_now  = regs.enable & button_level;
        r.pressed    = pressed_now;
        if (pressed_now != reported_pressed) begin
          r.tone_valid     = 1'b1;
          r.tone_hz        = pressed_now ? PressHz : ReleaseHz;
          r.tone_ms        = ButtonMs;
          reported_pressed = pressed_now;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] expv,
                             logic signed [31:0] actv);
    if (actv !== expv) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs             = '{enable: 1'b1, quiet_timeout_ms: TimeoutReset,
                           pitch_start: PitchStartReset, pitch_step: PitchStepReset,
                           pitch_min: PitchMinReset, pitch_max: PitchMaxReset};
      detent_count     = 0;
      counting_blocked = 1'b0;
      button_level     = 1'b0;
      reported_pressed = 1'b0;
      pitch_now        = PitchStartReset;
      quiet_elapsed    = '0;
      pending_feedback.delete();
    end else begin
      // Compare a delivered result against the oldest one owed
      if (out_valid && out_ready) begin
        results_checked++;
        if (tone_valid === 1'b1) tones_heard++;
        if (pending_feedback.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: result with no request pending, expected none, got diff %0d",
                     $time, diff_out);
        end else begin
          want = pending_feedback.pop_front();
          check_field("diff_out", want.diff, diff_out);
          check_field("pressed_out", want.pressed, pressed_out);
          check_field("tone_valid", want.tone_valid, tone_valid);
          check_field("tone_hz", want.tone_hz, tone_hz);
          check_field("tone_ms", want.tone_ms, tone_ms);
        end
      end
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegEnable:       regs.enable           = cfg_data[0];
          RegQuietTimeout: regs.quiet_timeout_ms = cfg_data;
          RegPitchStart:   regs.pitch_start      = cfg_data[14:0];
          RegPitchStep:    regs.pitch_step       = cfg_data[9:0];
          RegPitchMin:     regs.pitch_min        = cfg_data[14:0];
          RegPitchMax:     regs.pitch_max        = cfg_data[14:0];
          default: ;
        endcase
      end
      // Accepted request
      if (in_valid && in_ready)
        pending_feedback.push_back(feedback_for_request(req_kind_t'(req_type), line_a,
                                                        line_b, button_low));
    end
    outstanding <= pending_feedback.size();
  end

endmodule

@@ verif/rotary_encoder_pitch_feedback_core_test.sv @@
module rotary_encoder_pitch_feedback_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import repf_pkg::*;

  localparam int CountWidth    = 16;
  localparam int HoldOffCycles = 120;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              req_type;
  logic                    line_a;
  logic                    line_b;
  logic                    button_low;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [15:0]      diff_out;
  logic                    pressed_out;
  logic                    tone_valid;
  logic [14:0]             tone_hz;
  logic [4:0]              tone_ms;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int tones_heard;

  // Flags shared by the request and result sides, and request-side tallies
  bit steady;
  int squeeze_ask;
  int squeeze_seen;
  int requests_sent;
  int settings_used;

  rotary_encoder_pitch_feedback_core #(
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .line_a     (line_a),
    .line_b     (line_b),
    .button_low (button_low),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .diff_out   (diff_out),
    .pressed_out(pressed_out),
    .tone_valid (tone_valid),
    .tone_hz    (tone_hz),
    .tone_ms    (tone_ms),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pitch_feedback_checker #(
    .COUNT_WIDTH(CountWidth)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .line_a         (line_a),
    .line_b         (line_b),
    .button_low     (button_low),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .diff_out       (diff_out),
    .pressed_out    (pressed_out),
    .tone_valid     (tone_valid),
    .tone_hz        (tone_hz),
    .tone_ms        (tone_ms),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .tones_heard    (tones_heard)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned request_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // Offer one request and hold it until taken
  task automatic send_req(req_kind_t kind, logic a, logic b, logic btn);
    int unsigned gap;
    in_valid   <= 1'b1;
    req_type   <= kind;
    line_a     <= a;
    line_b     <= b;
    button_low <= btn;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    gap = request_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Block is idle once every owed result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic en, logic [15:0] tmo, logic [14:0] start,
                               logic [9:0] step, logic [14:0] lo, logic [14:0] hi);
    wait_idle();
    write_reg(RegEnable, 16'(en));
    write_reg(RegQuietTimeout, tmo);
    write_reg(RegPitchStart, 16'(start));
    write_reg(RegPitchStep, 16'(step));
    write_reg(RegPitchMin, 16'(lo));
    write_reg(RegPitchMax, 16'(hi));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Turning runs, tick bursts, press and release, reads, and some noise
  task automatic run_random(int count, bit squeeze);
    int  sent;
    int  r;
    int  burst;
    int  steady_left;
    bit  dir_up;
    bit  held;
    bit  asked;
    logic a;
    sent        = 0;
    steady_left = 0;
    dir_up      = 1'b1;
    held        = 1'b0;
    asked       = 1'b0;
    while (sent < count) begin
      if (squeeze && !asked && sent >= count / 2) begin
        squeeze_ask++;
        asked = 1'b1;
      end
      if (steady_left > 0) begin
        steady_left--;
        steady = (steady_left != 0);
      end else if ($urandom_range(0, 99) < 2) begin
        steady_left = $urandom_range(20, 50);
        steady      = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 38) begin
        if ($urandom_range(0, 99) < 15) dir_up = !dir_up;
        a = 1'($urandom_range(0, 1));
        send_req(REQ_EDGE, a, dir_up ? !a : a, 1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 62) begin
        burst = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 70) : $urandom_range(1, 3);
        repeat (burst) begin
          send_req(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          sent++;
        end
      end else if (r < 74) begin
        if (held) held = ($urandom_range(0, 99) < 40);
        else held = ($urandom_range(0, 99) < 30);
        send_req(REQ_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), held);
        sent++;
      end else if (r < 94) begin
        send_req(REQ_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_req(req_kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, and long hold-offs when asked
  initial begin
    forever begin
      if (squeeze_ask != squeeze_seen) begin
        squeeze_seen = squeeze_ask;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else if (steady || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // Request side and verdict
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_TICK;
    line_a     <= 1'b0;
    line_b     <= 1'b0;
    button_low <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= RegEnable;
    cfg_data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Each line combination turning up or down, blocking by the button,
    // press and release tones, a read with no change
    send_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b1, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b0, 1'b1, 1'b0);
    send_req(REQ_EDGE, 1'b0, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b1, 1'b1, 1'b0);
    send_req(REQ_EDGE, 1'b1, 1'b0, 1'b0);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);
    send_req(REQ_BUTTON, 1'b0, 1'b0, 1'b1);
    send_req(REQ_EDGE, 1'b1, 1'b0, 1'b1);
    send_req(REQ_READ, 1'b1, 1'b1, 1'b1);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);
    send_req(REQ_BUTTON, 1'b1, 1'b1, 1'b0);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);

    // Inverted pitch bounds with a zero quiet timeout
    apply_setting(1'b1, 16'd0, 15'd20000, 10'd1000, 15'd1500, 15'd1400);
    send_req(REQ_EDGE, 1'b1, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b0, 1'b0, 1'b0);
    send_req(REQ_TICK, 1'b0, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b0, 1'b1, 1'b0);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);

    // Disabled: button is seen but neither blocks nor reports
    apply_setting(1'b0, TimeoutReset, PitchStartReset, PitchStepReset, PitchMinReset,
                  PitchMaxReset);
    send_req(REQ_BUTTON, 1'b0, 1'b0, 1'b1);
    send_req(REQ_EDGE, 1'b1, 1'b0, 1'b0);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);

    // Enabled again with the level still held but counting not blocked
    apply_setting(1'b1, TimeoutReset, PitchStartReset, PitchStepReset, PitchMinReset,
                  PitchMaxReset);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);
    send_req(REQ_EDGE, 1'b0, 1'b1, 1'b0);
    send_req(REQ_BUTTON, 1'b0, 1'b0, 1'b0);
    send_req(REQ_READ, 1'b0, 1'b0, 1'b0);

    // Random traffic across several settings
    apply_setting(1'b1, 16'd25, 15'd2000, 10'd100, 15'd100, 15'd20000);
    run_random(250, 1'b1);
    apply_setting(1'b1, 16'd0, 15'd1, 10'd1000, 15'd1, 15'd20000);
    run_random(250, 1'b0);
    apply_setting(1'b0, 16'd65535, 15'd20000, 10'd0, 15'd20000, 15'd1);
    run_random(150, 1'b0);
    apply_setting(1'b1, 16'd10, 15'($urandom_range(1, 20000)), 10'($urandom_range(0, 1000)),
                  15'd6000, 15'd3000);
    run_random(250, 1'b0);
    repeat (2) begin
      apply_setting(1'b1, 16'($urandom_range(0, 40)), 15'($urandom_range(1, 20000)),
                    10'($urandom_range(0, 1000)), 15'($urandom_range(1, 20000)),
                    15'($urandom_range(1, 20000)));
      run_random(200, 1'b1);
    end
    apply_setting(1'b1, 16'd65535, 15'd20000, 10'd1000, 15'd1, 15'd20000);
    run_random(150, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("summary: %0d requests under %0d register settings, with directed corners",
             requests_sent, settings_used);
    $display("summary: %0d results compared, %0d of them with a tone, %0d mismatches",
             results_checked, tones_heard, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("tb: failure");
    $finish;
  end

endmodule
